### rtl/core/pdu_pkg.sv
package pdu_pkg;

  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] ChF     = 8'h46;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] CaseMask = 8'hDF;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_e;

  // Everything the decoder derives from one held item and the current state.
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] byte0;
    logic       last0;
    logic [7:0] byte1;
    logic       last1;
    phase_e     phase;
    logic [3:0] high_nibble;
  } dec_t;

  function automatic logic first_digit_ok(input logic [7:0] c);
    return ((c >= ChA) && (c <= ChF)) || ((c >= Ch0) && (c <= Ch9));
  endfunction

  function automatic logic [7:0] digit_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= ChA) begin
      v = (c & CaseMask) - ChA + 8'd10;
    end else begin
      v = c - Ch0;
    end
    return v;
  endfunction

endpackage

### rtl/core/pdu_decode.sv
module pdu_decode (
  input  logic              xml_only_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  input  pdu_pkg::phase_e   phase_i,
  input  logic [3:0]        high_nibble_i,
  output pdu_pkg::dec_t     dec_o
);

  logic [7:0] c;
  logic [7:0] dval;

  assign c    = (!xml_only_i && (byte_i == pdu_pkg::ChPlus)) ? pdu_pkg::ChSpace : byte_i;
  assign dval = pdu_pkg::digit_val(c);

  always_comb begin
    dec_o             = '0;
    dec_o.phase       = pdu_pkg::PH_IDLE;
    dec_o.high_nibble = high_nibble_i;
    unique case (phase_i)
      pdu_pkg::PH_PCT: begin
        if (pdu_pkg::first_digit_ok(c)) begin
          if (last_i) begin
            // Escape cut short by the end of the string: send it raw.
            dec_o.count = 2'd2;
            dec_o.byte0 = pdu_pkg::ChPct;
            dec_o.byte1 = c;
            dec_o.last1 = 1'b1;
          end else begin
            dec_o.phase       = pdu_pkg::PH_DIGIT;
            dec_o.high_nibble = dval[3:0];
          end
        end else begin
          dec_o.byte0 = pdu_pkg::ChPct;
          if ((c == pdu_pkg::ChPct) && !last_i) begin
            dec_o.count = 2'd1;
            dec_o.phase = pdu_pkg::PH_PCT;
          end else begin
            dec_o.count = 2'd2;
            dec_o.byte1 = c;
            dec_o.last1 = last_i;
          end
        end
      end
      pdu_pkg::PH_DIGIT: begin
        dec_o.count = 2'd1;
        dec_o.byte0 = {high_nibble_i, 4'b0000} + dval;
        dec_o.last0 = last_i;
      end
      default: begin
        if ((c == pdu_pkg::ChPct) && !last_i) begin
          dec_o.phase = pdu_pkg::PH_PCT;
        end else begin
          dec_o.count = 2'd1;
          dec_o.byte0 = c;
          dec_o.last0 = last_i;
        end
      end
    endcase
  end

endmodule

### rtl/core/pdu_out_stage.sv
module pdu_out_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output logic       can_load_o,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] out_byte
  output logic       m_axis_tlast_o   // out_last
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;

  assign can_load_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (can_load_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load_o && load_i) begin
      byte_q <= byte_i;
      last_q <= last_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = byte_q;
  assign m_axis_tlast_o  = last_q;

endmodule

### rtl/core/percent_decoder_unit.sv
// Streaming percent decoder for encoded strings.
// Slave channel s_axis_*: one encoded character per transfer in tdata, tlast on
// the final character of a string. Master channel m_axis_*: decoded characters,
// tlast on the final decoded character. A '+' becomes a space unless xml_only is
// set through cfg_we_i/cfg_wdata_i, which may be written only while the block
// is idle.
// An accepted character is held in the input register, where it is
// decoded against the escape state; its result is then loaded into the output
// register, which presents it on the master channel.
// While the receiver keeps up, one character is accepted per cycle. A character
// that yields two results (a rejected or truncated escape) holds the input register
// until both are loaded, as the single output register takes one result per cycle;
// a '%' that opens an escape or a pending first digit yields none and frees it at once.
// Reset clears the escape state, xml_only and both valid flags.
// When the receiver stalls, the output register holds its result, a held character
// that has results waits in the input register and s_axis_tready_o drops.
module percent_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,     // xml_only
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] in_byte
  input  logic       s_axis_tlast_i,  // in_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] out_byte
  output logic       m_axis_tlast_o   // out_last
);

  logic             xml_only_q;
  logic             in_valid_q, in_valid_d;
  logic [7:0]       in_byte_q;
  logic             in_last_q;
  logic             sel_q, sel_d;
  pdu_pkg::phase_e  phase_q, phase_d;
  logic [3:0]       high_nibble_q, high_nibble_d;
  pdu_pkg::dec_t    dec;
  logic             can_load;
  logic             emit;
  logic             done;
  logic             s_take;
  logic [7:0]       emit_byte;
  logic             emit_last;

  pdu_decode u_decode (
    .xml_only_i   (xml_only_q),
    .byte_i       (in_byte_q),
    .last_i       (in_last_q),
    .phase_i      (phase_q),
    .high_nibble_i(high_nibble_q),
    .dec_o        (dec)
  );

  assign emit = in_valid_q && (dec.count != 2'd0) && can_load;
  // The held item is finished once its last result goes out, or at once if it has none.
  assign done = in_valid_q &&
                ((dec.count == 2'd0) || (can_load && (sel_q || (dec.count == 2'd1))));
  assign s_axis_tready_o = !in_valid_q || done;
  assign s_take = s_axis_tvalid_i && s_axis_tready_o;

  assign emit_byte = sel_q ? dec.byte1 : dec.byte0;
  assign emit_last = sel_q ? dec.last1 : dec.last0;

  always_comb begin
    in_valid_d    = in_valid_q;
    sel_d         = sel_q;
    phase_d       = phase_q;
    high_nibble_d = high_nibble_q;
    if (done) begin
      in_valid_d    = 1'b0;
      sel_d         = 1'b0;
      phase_d       = dec.phase;
      high_nibble_d = dec.high_nibble;
    end else if (emit) begin
      sel_d = 1'b1;
    end
    if (s_take) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xml_only_q    <= 1'b0;
      in_valid_q    <= 1'b0;
      sel_q         <= 1'b0;
      phase_q       <= pdu_pkg::PH_IDLE;
      high_nibble_q <= 4'd0;
    end else begin
      if (cfg_we_i) begin
        xml_only_q <= cfg_wdata_i;
      end
      in_valid_q    <= in_valid_d;
      sel_q         <= sel_d;
      phase_q       <= phase_d;
      high_nibble_q <= high_nibble_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  pdu_out_stage u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (emit),
    .byte_i         (emit_byte),
    .last_i         (emit_last),
    .can_load_o     (can_load),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // The second result of an item is only ever pending while that item is held.
  a_sel_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> (in_valid_q && (dec.count == 2'd2)))
    else $error("second-result flag set without a two-result item");

  // Input stalls come from a busy output register or from the first half of a
  // two-result item.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && ((m_axis_tvalid_o && !m_axis_tready_i) ||
                                         ((dec.count == 2'd2) && !sel_q))))
    else $error("input stalled while output register could load");

  // An item that yields nothing always leaves an escape open.
  a_silent_opens_escape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && (dec.count == 2'd0)) |=> (phase_q != pdu_pkg::PH_IDLE))
    else $error("item without results left the decoder idle");

  // A result carrying the end of a string leaves no escape pending.
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && emit && emit_last) |=> (phase_q == pdu_pkg::PH_IDLE))
    else $error("escape still open after final result");

endmodule
